// File: hw/rtl/epoch_priority_task_scheduler_top_defines.svh
// assertion macros shared by the scheduler rtl
`ifndef EPOCH_PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH
`define EPOCH_PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define EPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen out of reset
`define EPTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/epts_pkg.sv
// types and constants of the task scheduler
package epts_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 64;
  localparam int unsigned PRIO_BITS_DEF = 8;

  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned PRIO_REQ_W  = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ID_W        = 6;
  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned M_FIELDS_W  = 17;
  localparam int unsigned M_TDATA_W   = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_YIELD  = 2'd2,
    OP_EXIT   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_NO_RUN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_CLEAR_RUN,
    ST_SCAN,
    ST_EVAL,
    ST_RECALC,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find_step;
    logic create_wr;
    logic tick_wr;
    logic zero_run;
    logic exit_clr;
    logic scan_run;
    logic recalc;
    logic commit;
    logic go_idle;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic count_zero;
    logic run_present;
    logic free_hit;
    logic credit_gt1;
    logic scan_last;
    logic best_found;
  } dp_stat_t;

endpackage

// File: hw/rtl/epts_datapath.sv
// slot table, credit and priority memories, scan and pick logic
`include "epoch_priority_task_scheduler_top_defines.svh"

module epts_datapath #(
  parameter int unsigned NUM_SLOTS = epts_pkg::NUM_SLOTS_DEF,
  parameter int unsigned PRIO_BITS = epts_pkg::PRIO_BITS_DEF,
  localparam int unsigned SlotW    = $clog2(NUM_SLOTS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  epts_pkg::dp_cmd_t               cmd_i,
  input  logic [epts_pkg::PRIO_REQ_W-1:0] prio_req_i,
  output epts_pkg::dp_stat_t              stat_o,
  output logic [SlotW-1:0]                new_id_o,
  output logic [SlotW-1:0]                running_id_o,
  output logic                            running_valid_o
);
  import epts_pkg::*;

  localparam int unsigned CredW = PRIO_BITS + 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CmpW  = (PRIO_BITS > PRIO_REQ_W) ? PRIO_BITS : PRIO_REQ_W;
  localparam logic [CmpW-1:0]  PrioMaxExt = CmpW'({PRIO_BITS{1'b1}});
  localparam logic [SlotW-1:0] LastSlot   = SlotW'(NUM_SLOTS - 1);

  // memories
  logic [CredW-1:0]     credit_mem [NUM_SLOTS];
  logic [PRIO_BITS-1:0] base_mem   [NUM_SLOTS];

  // control state
  logic [NUM_SLOTS-1:0] used_q;
  logic [CntW-1:0]      count_q;
  logic [SlotW-1:0]     running_q;
  logic                 present_q;
  logic [SlotW-1:0]     idx_q;
  logic                 issued_all_q;
  logic                 rd_vld_q;
  logic [SlotW-1:0]     rd_idx_q;
  logic                 best_found_q;

  // payload
  logic [PRIO_BITS-1:0] prio_q;
  logic [SlotW-1:0]     new_id_q;
  logic [CredW-1:0]     best_q;
  logic [SlotW-1:0]     best_idx_q;
  logic [CredW-1:0]     rd_credit_q;
  logic [PRIO_BITS-1:0] rd_base_q;

  logic [CmpW-1:0]      req_ext;
  logic [PRIO_BITS-1:0] prio_sat;
  logic [SlotW-1:0]     rd_addr;
  logic [CredW-1:0]     recalc_val;
  logic [CredW-1:0]     cand_val;
  logic                 cand_used;
  logic                 cand_ok;
  logic                 first_issue;
  logic                 cr_we;
  logic [SlotW-1:0]     cr_waddr;
  logic [CredW-1:0]     cr_wdata;

  // saturate to the top priority, zero taken as one
  always_comb begin
    req_ext  = CmpW'(prio_req_i);
    prio_sat = (req_ext > PrioMaxExt) ? PRIO_BITS'(PrioMaxExt) : PRIO_BITS'(req_ext);
    if (prio_sat == '0) begin
      prio_sat = PRIO_BITS'(1);
    end
  end

  assign rd_addr     = cmd_i.scan_run ? idx_q : running_q;
  assign recalc_val  = CredW'(rd_credit_q >> 1) + CredW'(rd_base_q);
  assign cand_used   = used_q[rd_idx_q];
  assign cand_val    = cmd_i.recalc ? recalc_val : rd_credit_q;
  assign cand_ok     = rd_vld_q && cand_used && (cand_val > best_q);
  assign first_issue = cmd_i.scan_run && !issued_all_q && (idx_q == '0);

  // single credit write port
  always_comb begin
    cr_we    = 1'b0;
    cr_waddr = running_q;
    cr_wdata = '0;
    if (cmd_i.create_wr) begin
      cr_we    = 1'b1;
      cr_waddr = idx_q;
    end else if (cmd_i.tick_wr) begin
      cr_we    = 1'b1;
      cr_wdata = stat_o.credit_gt1 ? (rd_credit_q - CredW'(1)) : '0;
    end else if (cmd_i.zero_run || cmd_i.exit_clr) begin
      cr_we    = 1'b1;
    end else if (cmd_i.recalc && rd_vld_q && cand_used) begin
      cr_we    = 1'b1;
      cr_waddr = rd_idx_q;
      cr_wdata = recalc_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr_we) begin
      credit_mem[cr_waddr] <= cr_wdata;
    end
    if (cmd_i.create_wr) begin
      base_mem[idx_q] <= prio_q;
    end
    rd_credit_q <= credit_mem[rd_addr];
    rd_base_q   <= base_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prio_q   <= prio_sat;
      new_id_q <= '0;
    end else if (cmd_i.create_wr) begin
      new_id_q <= idx_q;
    end
    if (first_issue) begin
      best_q <= '0;
    end else if (cand_ok) begin
      best_q     <= cand_val;
      best_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      count_q      <= '0;
      running_q    <= '0;
      present_q    <= 1'b0;
      idx_q        <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_found_q <= 1'b0;
    end else begin
      if (cmd_i.create_wr) begin
        used_q[idx_q] <= 1'b1;
        count_q       <= count_q + CntW'(1);
      end
      if (cmd_i.exit_clr) begin
        used_q[running_q] <= 1'b0;
        count_q           <= count_q - CntW'(1);
      end

      if (cmd_i.exit_clr || cmd_i.go_idle) begin
        running_q <= '0;
        present_q <= 1'b0;
      end else if (cmd_i.commit) begin
        running_q <= best_idx_q;
        present_q <= 1'b1;
      end

      // slot walk: one read issued a cycle, compared the cycle after
      if (cmd_i.scan_run) begin
        rd_vld_q <= !issued_all_q;
        rd_idx_q <= idx_q;
        if (!issued_all_q) begin
          if (idx_q == LastSlot) begin
            issued_all_q <= 1'b1;
          end else begin
            idx_q <= idx_q + SlotW'(1);
          end
        end
      end else begin
        rd_vld_q     <= 1'b0;
        issued_all_q <= 1'b0;
        if (cmd_i.find_step) begin
          idx_q <= idx_q + SlotW'(1);
        end else begin
          idx_q <= '0;
        end
      end

      if (first_issue) begin
        best_found_q <= 1'b0;
      end else if (cand_ok) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.full        = (count_q == CntW'(NUM_SLOTS));
    stat_o.count_zero  = (count_q == '0);
    stat_o.run_present = present_q;
    stat_o.free_hit    = !used_q[idx_q];
    stat_o.credit_gt1  = (rd_credit_q > CredW'(1));
    stat_o.scan_last   = rd_vld_q && (rd_idx_q == LastSlot);
    stat_o.best_found  = best_found_q;
  end

  assign new_id_o        = new_id_q;
  assign running_id_o    = running_q;
  assign running_valid_o = present_q;

  `EPTS_ASSERT(a_count_matches_used, ($countones(used_q) == int'(count_q)), "task count off")
  `EPTS_ASSERT(a_running_is_used, present_q |-> used_q[running_q], "running slot not in use")
  `EPTS_ASSERT(a_commit_has_pick, cmd_i.commit |-> best_found_q, "commit without a pick")

endmodule

// File: hw/rtl/epts_ctrl.sv
// sequencer for create, tick, yield, exit and the scheduling passes
`include "epoch_priority_task_scheduler_top_defines.svh"

module epts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  epts_pkg::opcode_e   s_opcode_i,
  output logic                s_ready_o,
  input  logic                out_free_i,
  output logic                out_load_o,
  input  epts_pkg::dp_stat_t  stat_i,
  output epts_pkg::dp_cmd_t   cmd_o,
  output epts_pkg::status_e   status_o,
  output logic                switched_o,
  output logic                recalc_o
);
  import epts_pkg::*;

  state_e  state_q, state_d;
  opcode_e op_q, op_d;
  status_e status_q, status_d;
  logic    sw_q, sw_d;
  logic    recalc_q, recalc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_CREATE;
      status_q <= STATUS_OK;
      sw_q     <= 1'b0;
      recalc_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
      sw_q     <= sw_d;
      recalc_q <= recalc_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    status_d   = status_q;
    sw_d       = sw_q;
    recalc_d   = recalc_q;
    cmd_o      = '0;
    s_ready_o  = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = s_opcode_i;
          status_d   = STATUS_OK;
          sw_d       = 1'b0;
          recalc_d   = 1'b0;
          case (s_opcode_i)
            OP_CREATE: begin
              if (stat_i.full) begin
                status_d = STATUS_FULL;
                state_d  = ST_DONE;
              end else begin
                state_d  = ST_FIND;
              end
            end
            OP_TICK: begin
              state_d = stat_i.run_present ? ST_TICK_RD : ST_SCAN;
            end
            OP_YIELD: begin
              state_d = stat_i.run_present ? ST_CLEAR_RUN : ST_SCAN;
            end
            OP_EXIT: begin
              if (stat_i.run_present) begin
                state_d  = ST_CLEAR_RUN;
              end else begin
                status_d = STATUS_NO_RUN;
                state_d  = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_FIND: begin
        cmd_o.find_step = 1'b1;
        if (stat_i.free_hit) begin
          cmd_o.create_wr = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_TICK_RD: begin
        state_d = ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        cmd_o.tick_wr = 1'b1;
        state_d       = stat_i.credit_gt1 ? ST_DONE : ST_SCAN;
      end
      ST_CLEAR_RUN: begin
        if (op_q == OP_EXIT) begin
          cmd_o.exit_clr = 1'b1;
        end else begin
          cmd_o.zero_run = 1'b1;
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_RECALC: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.recalc   = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.best_found) begin
          cmd_o.commit = 1'b1;
          sw_d         = 1'b1;
          state_d      = ST_DONE;
        end else if (!recalc_q && !stat_i.count_zero) begin
          recalc_d = 1'b1;
          state_d  = ST_RECALC;
        end else begin
          cmd_o.go_idle = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o   = status_q;
  assign switched_o = sw_q;
  assign recalc_o   = recalc_q;

  `EPTS_ASSERT(a_recalc_always_picks, (state_q == ST_EVAL && recalc_q) |-> stat_i.best_found, "no pick after recalc")
  `EPTS_ASSERT_NEVER(a_find_when_full, (state_q == ST_FIND) && stat_i.full, "free slot search on full table")
  `EPTS_ASSERT(a_clear_needs_running, (state_q == ST_CLEAR_RUN) |-> stat_i.run_present, "clear without running task")

endmodule

// File: hw/rtl/epoch_priority_task_scheduler_top.sv
// top level of the epoch priority task scheduler
// paths from the accepting cycle: refused create or idle exit straight to the result,
// create by a free slot search, tick without preemption by a credit read and write,
//   reschedule a slot walk, with recalculation a second, one slot read a cycle on each walk
// throughput: one item at a time, the next taken while the result waits in the output register
// reset: slot table, task count and running task cleared at once, no clearing pass
module epoch_priority_task_scheduler_top #(
  parameter int unsigned NUM_SLOTS = epts_pkg::NUM_SLOTS_DEF,
  parameter int unsigned PRIO_BITS = epts_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [epts_pkg::S_TDATA_W-1:0] s_axis_tdata,  // priority_req[7:0]
  input  logic [epts_pkg::S_TUSER_W-1:0] s_axis_tuser,  // opcode[1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], new_task_id[7:2], running_id[13:8], running_valid[14],
  // switched[15], recalculated[16], zero fill above
  output logic [epts_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import epts_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  status_e          status;
  logic             switched;
  logic             recalc;
  logic             out_load;
  logic             out_free;
  logic [SlotW-1:0] new_id;
  logic [SlotW-1:0] running_id;
  logic             running_valid;

  // result register, parts the result side from the sequencer
  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic [M_FIELDS_W-1:0] out_fields;

  epts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (opcode_e'(s_axis_tuser)),
    .s_ready_o  (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .status_o   (status),
    .switched_o (switched),
    .recalc_o   (recalc)
  );

  epts_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .prio_req_i      (s_axis_tdata),
    .stat_o          (stat),
    .new_id_o        (new_id),
    .running_id_o    (running_id),
    .running_valid_o (running_valid)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  // ids are reported in the fixed result field width
  assign out_fields = {recalc, switched, running_valid, ID_W'(running_id), ID_W'(new_id),
                       status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= M_TDATA_W'(out_fields);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
